// ===== hdl/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety check package
// Shared sizes, command codes, sequencer states and bus structs of the
// deadlock-avoidance safety check unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_RES    = 16;
  localparam int COUNT_BITS = 16;

  localparam int PROC_BITS  = $clog2(MAX_PROCS);
  localparam int RES_BITS   = $clog2(MAX_RES);
  localparam int ADDR_BITS  = PROC_BITS + RES_BITS;
  localparam int TBL_DEPTH  = MAX_PROCS * MAX_RES;
  localparam int WORK_BITS  = COUNT_BITS + 4;
  localparam int CFG_BITS   = 5;
  localparam int PCNT_BITS  = $clog2(MAX_PROCS + 1);
  localparam int RCNT_BITS  = $clog2(MAX_RES + 1);

  // Input transaction kinds.
  typedef enum logic [1:0] {
    CMD_LOAD_MAX   = 2'd0,
    CMD_LOAD_ALLOC = 2'd1,
    CMD_LOAD_AVAIL = 2'd2,
    CMD_RUN        = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic REG_PROCESS_COUNT  = 1'b0;
  localparam logic REG_RESOURCE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT_RD,
    ST_FIT_CMP,
    ST_ACC_RD,
    ST_ACC_ADD,
    ST_EMIT,
    ST_VERDICT
  } state_t;

  // Write request into the claim and allocation tables.
  typedef struct packed {
    logic                  max_we;
    logic                  alloc_we;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } tbl_wr_t;

  // Registered read data of both tables at one address.
  typedef struct packed {
    logic [COUNT_BITS-1:0] max_claim;
    logic [COUNT_BITS-1:0] allocated;
  } tbl_rd_t;

  // A zero count register means one; anything above the maximum means the maximum.
  function automatic logic [PCNT_BITS-1:0] clamp_procs(input logic [CFG_BITS-1:0] v);
    logic [PCNT_BITS-1:0] res;
    if (v == '0) begin
      res = PCNT_BITS'(1);
    end else if (32'(v) > MAX_PROCS) begin
      res = PCNT_BITS'(MAX_PROCS);
    end else begin
      res = PCNT_BITS'(v);
    end
    return res;
  endfunction

  function automatic logic [RCNT_BITS-1:0] clamp_res(input logic [CFG_BITS-1:0] v);
    logic [RCNT_BITS-1:0] res;
    if (v == '0) begin
      res = RCNT_BITS'(1);
    end else if (32'(v) > MAX_RES) begin
      res = RCNT_BITS'(MAX_RES);
    end else begin
      res = RCNT_BITS'(v);
    end
    return res;
  endfunction

endpackage

// ===== hdl/bsc_tables.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Claim and allocation tables
// Two memories indexed by {process, resource}, sharing one write address and
// one read address; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsc_tables (
  input  logic                          clk,
  input  bsc_pkg::tbl_wr_t              wr,
  input  logic [bsc_pkg::ADDR_BITS-1:0] rd_addr,
  output bsc_pkg::tbl_rd_t              rd
);

  logic [bsc_pkg::COUNT_BITS-1:0] max_mem   [bsc_pkg::TBL_DEPTH];
  logic [bsc_pkg::COUNT_BITS-1:0] alloc_mem [bsc_pkg::TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.max_we) begin
      max_mem[wr.addr] <= wr.data;
    end
    if (wr.alloc_we) begin
      alloc_mem[wr.addr] <= wr.data;
    end
    rd.max_claim <= max_mem[rd_addr];
    rd.allocated <= alloc_mem[rd_addr];
  end

endmodule

// ===== hdl/bsc_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety check arithmetic unit
// Signed need-versus-work compare and saturating work accumulate for one
// resource at a time.
// ----------------------------------------------------------------------------
module bsc_alu (
  input  bsc_pkg::tbl_rd_t              rd,
  input  logic [bsc_pkg::WORK_BITS-1:0] work,
  output logic                          fit,
  output logic [bsc_pkg::WORK_BITS-1:0] work_sum
);

  logic signed [bsc_pkg::WORK_BITS:0] need;
  logic signed [bsc_pkg::WORK_BITS:0] work_s;
  logic        [bsc_pkg::WORK_BITS:0] sum;

  always_comb begin
    // Need may go negative when an entry is over-allocated; it then always fits.
    need     = $signed({(bsc_pkg::WORK_BITS + 1 - bsc_pkg::COUNT_BITS)'(0), rd.max_claim})
             - $signed({(bsc_pkg::WORK_BITS + 1 - bsc_pkg::COUNT_BITS)'(0), rd.allocated});
    work_s   = $signed({1'b0, work});
    fit      = (need <= work_s);
    sum      = {1'b0, work} + (bsc_pkg::WORK_BITS + 1)'(rd.allocated);
    work_sum = sum[bsc_pkg::WORK_BITS] ? '1 : sum[bsc_pkg::WORK_BITS-1:0];
  end

endmodule

// ===== hdl/bankers_safety_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety check unit
// Sequencer that runs the deadlock-avoidance safety check over stored
// claim and allocation tables, one resource entry at a time.
// ----------------------------------------------------------------------------
// Usage: load transactions on the in_ channel (kind in in_tuser) write one
// maximum-claim entry, one allocated entry or one available count and
// produce no output. A run transaction copies the available counts into
// the work vector and scans the processes from index zero. Each granted
// process leaves as one out_ transaction carrying its index, and the run
// closes with a verdict transaction (out_tuser high, out_tlast high, safe
// flag in out_tdata).
// Steps: testing one process reads the table, then compares, for each
// resource in use, stopping at the first resource that does not fit;
// granting it reads, then adds, for each resource, and then emits. A
// finished process is skipped without a compare. The scan handles one
// resource entry at a time, as there is a single table read port and
// one shared compare/add unit. in_tready stays low for the whole run.
// Results sit in an output register; when the receiver stalls the scan
// waits at the next emit step. Reset sets both counts to one, clears the
// finish marks and empties the output register; table contents are kept.
// ----------------------------------------------------------------------------
module bankers_safety_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] process_index, [7:4] resource_index, [23:8] amount
  input  logic [1:0]  in_tuser,   // [1:0] command
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] sequence_process, [4] safe, [7:5] zero
  output logic        out_tuser,  // [0] is_verdict
  output logic        out_tlast
);

  localparam int PB = bsc_pkg::PROC_BITS;
  localparam int RB = bsc_pkg::RES_BITS;
  localparam int WB = bsc_pkg::WORK_BITS;
  localparam int CB = bsc_pkg::COUNT_BITS;

  // Configuration registers.
  logic [bsc_pkg::CFG_BITS-1:0] proc_cfg_r;
  logic [bsc_pkg::CFG_BITS-1:0] res_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_cfg_r <= bsc_pkg::CFG_BITS'(1);
      res_cfg_r  <= bsc_pkg::CFG_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == bsc_pkg::REG_PROCESS_COUNT) begin
        proc_cfg_r <= cfg_wdata;
      end else begin
        res_cfg_r <= cfg_wdata;
      end
    end
  end

  logic [bsc_pkg::PCNT_BITS-1:0] np;
  logic [bsc_pkg::RCNT_BITS-1:0] nr;

  assign np = bsc_pkg::clamp_procs(proc_cfg_r);
  assign nr = bsc_pkg::clamp_res(res_cfg_r);

  // Input unpacking.
  logic              in_acc;
  bsc_pkg::cmd_t     in_cmd;
  logic [PB-1:0]     in_proc;
  logic [RB-1:0]     in_res;
  logic [CB-1:0]     in_amount;

  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = bsc_pkg::cmd_t'(in_tuser);
  assign in_proc   = in_tdata[PB-1:0];
  assign in_res    = in_tdata[PB+RB-1:PB];
  assign in_amount = in_tdata[PB+RB+CB-1:PB+RB];

  // Sequencer state.
  bsc_pkg::state_t               state_r, state_nxt;
  logic [bsc_pkg::PCNT_BITS-1:0] proc_r, proc_nxt;
  logic [bsc_pkg::RCNT_BITS-1:0] res_r, res_nxt;
  logic [bsc_pkg::MAX_PROCS-1:0] fin_r;
  logic [bsc_pkg::PCNT_BITS-1:0] fin_cnt_r;
  logic [CB-1:0]                 avail_r [bsc_pkg::MAX_RES];
  logic [WB-1:0]                 work_r  [bsc_pkg::MAX_RES];

  // Output register.
  logic          out_valid_r;
  logic [PB-1:0] out_proc_r;
  logic          out_verdict_r;
  logic          out_safe_r;

  // Tables and shared arithmetic.
  bsc_pkg::tbl_wr_t tbl_wr;
  bsc_pkg::tbl_rd_t tbl_rd;
  logic             fit;
  logic [WB-1:0]    work_sum;

  always_comb begin
    tbl_wr.max_we   = in_acc && (in_cmd == bsc_pkg::CMD_LOAD_MAX);
    tbl_wr.alloc_we = in_acc && (in_cmd == bsc_pkg::CMD_LOAD_ALLOC);
    tbl_wr.addr     = {in_proc, in_res};
    tbl_wr.data     = in_amount;
  end

  bsc_tables u_tables (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr ({proc_r[PB-1:0], res_r[RB-1:0]}),
    .rd      (tbl_rd)
  );

  bsc_alu u_alu (
    .rd       (tbl_rd),
    .work     (work_r[res_r[RB-1:0]]),
    .fit      (fit),
    .work_sum (work_sum)
  );

  // Control strobes from the sequencer.
  logic run_start;
  logic work_we;
  logic grant;
  logic out_slot;
  logic out_load_verdict;

  assign out_slot  = !out_valid_r || out_tready;
  assign in_tready = (state_r == bsc_pkg::ST_IDLE);
  assign run_start = in_acc && (in_cmd == bsc_pkg::CMD_RUN);

  always_comb begin
    state_nxt        = state_r;
    proc_nxt         = proc_r;
    res_nxt          = res_r;
    work_we          = 1'b0;
    grant            = 1'b0;
    out_load_verdict = 1'b0;
    case (state_r)
      bsc_pkg::ST_IDLE: begin
        if (run_start) begin
          proc_nxt  = '0;
          res_nxt   = '0;
          state_nxt = bsc_pkg::ST_FIT_RD;
        end
      end
      bsc_pkg::ST_FIT_RD: begin
        // Finished processes are skipped without touching the tables.
        if (fin_r[proc_r[PB-1:0]]) begin
          proc_nxt = proc_r + 1'b1;
          res_nxt  = '0;
          if (proc_r + 1'b1 >= np) begin
            state_nxt = bsc_pkg::ST_VERDICT;
          end
        end else begin
          state_nxt = bsc_pkg::ST_FIT_CMP;
        end
      end
      bsc_pkg::ST_FIT_CMP: begin
        if (!fit) begin
          proc_nxt  = proc_r + 1'b1;
          res_nxt   = '0;
          state_nxt = (proc_r + 1'b1 >= np) ? bsc_pkg::ST_VERDICT : bsc_pkg::ST_FIT_RD;
        end else if (bsc_pkg::RCNT_BITS'(res_r + 1'b1) == nr) begin
          res_nxt   = '0;
          state_nxt = bsc_pkg::ST_ACC_RD;
        end else begin
          res_nxt   = res_r + 1'b1;
          state_nxt = bsc_pkg::ST_FIT_RD;
        end
      end
      bsc_pkg::ST_ACC_RD: begin
        state_nxt = bsc_pkg::ST_ACC_ADD;
      end
      bsc_pkg::ST_ACC_ADD: begin
        work_we = 1'b1;
        if (bsc_pkg::RCNT_BITS'(res_r + 1'b1) == nr) begin
          res_nxt   = '0;
          state_nxt = bsc_pkg::ST_EMIT;
        end else begin
          res_nxt   = res_r + 1'b1;
          state_nxt = bsc_pkg::ST_ACC_RD;
        end
      end
      bsc_pkg::ST_EMIT: begin
        if (out_slot) begin
          grant     = 1'b1;
          proc_nxt  = '0;
          res_nxt   = '0;
          state_nxt = bsc_pkg::ST_FIT_RD;
        end
      end
      bsc_pkg::ST_VERDICT: begin
        if (out_slot) begin
          out_load_verdict = 1'b1;
          state_nxt        = bsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsc_pkg::ST_IDLE;
      proc_r      <= '0;
      res_r       <= '0;
      fin_r       <= '0;
      fin_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      proc_r  <= proc_nxt;
      res_r   <= res_nxt;
      if (run_start) begin
        fin_r     <= '0;
        fin_cnt_r <= '0;
      end else if (grant) begin
        fin_r[proc_r[PB-1:0]] <= 1'b1;
        fin_cnt_r             <= fin_cnt_r + 1'b1;
      end
      if (grant || out_load_verdict) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: available counts, work vector and output fields.
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == bsc_pkg::CMD_LOAD_AVAIL)) begin
      avail_r[in_res] <= in_amount;
    end
    for (int k = 0; k < bsc_pkg::MAX_RES; k++) begin
      if (run_start) begin
        work_r[k] <= (k < 32'(nr)) ? WB'(avail_r[k]) : '0;
      end
    end
    if (work_we) begin
      work_r[res_r[RB-1:0]] <= work_sum;
    end
    if (grant) begin
      out_proc_r    <= proc_r[PB-1:0];
      out_verdict_r <= 1'b0;
      out_safe_r    <= 1'b0;
    end else if (out_load_verdict) begin
      out_proc_r    <= '0;
      out_verdict_r <= 1'b1;
      out_safe_r    <= (fin_cnt_r == np);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_safe_r, out_proc_r};
  assign out_tuser  = out_verdict_r;
  assign out_tlast  = out_verdict_r;

endmodule

// ===== sim/bsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety check scoreboard
// Follows the configuration port and both streams of the safety check unit,
// keeps its own copy of the tables and counts, works out the safe sequence
// and verdict of every run and compares them in order with the results.
// ----------------------------------------------------------------------------
module bsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] process_index, [7:4] resource_index, [23:8] amount
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [3:0] sequence_process, [4] safe, [7:5] zero
  input  logic        out_tuser,  // [0] is_verdict
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);

  localparam int MAX_PROCS  = bsc_pkg::MAX_PROCS;
  localparam int MAX_RES    = bsc_pkg::MAX_RES;
  localparam int COUNT_BITS = bsc_pkg::COUNT_BITS;
  localparam int WORK_BITS  = bsc_pkg::WORK_BITS;
  localparam int PROC_BITS  = bsc_pkg::PROC_BITS;
  localparam int RES_BITS   = bsc_pkg::RES_BITS;
  localparam int CFG_BITS   = bsc_pkg::CFG_BITS;
  localparam int TBL_DEPTH  = bsc_pkg::TBL_DEPTH;
  localparam int WORK_MAX   = (1 << WORK_BITS) - 1;

  typedef struct packed {
    logic [PROC_BITS-1:0] proc_id;
    logic                 verdict;
    logic                 safe;
    logic                 last;
  } grant_t;

  logic [COUNT_BITS-1:0] claim_mem [TBL_DEPTH];
  logic [COUNT_BITS-1:0] alloc_mem [TBL_DEPTH];
  logic [COUNT_BITS-1:0] avail_mem [MAX_RES];
  logic [CFG_BITS-1:0]   procs_reg;
  logic [CFG_BITS-1:0]   res_reg;
  grant_t                grants_due [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Queues the grants of one run followed by its verdict.
  task automatic predict_safe_sequence();
    int                   np;
    int                   nr;
    int                   i;
    int                   granted;
    int                   need;
    int                   sum;
    bit                   passes;
    logic [WORK_BITS-1:0] work [MAX_RES];
    logic [MAX_PROCS-1:0] finished;
    np = (procs_reg == 0) ? 1 : ((procs_reg > MAX_PROCS) ? MAX_PROCS : int'(procs_reg));
    nr = (res_reg == 0) ? 1 : ((res_reg > MAX_RES) ? MAX_RES : int'(res_reg));
    for (int r = 0; r < MAX_RES; r++) begin
      work[r] = (r < nr) ? WORK_BITS'(avail_mem[r]) : '0;
    end
    finished = '0;
    granted  = 0;
    i        = 0;
    while (i < np) begin
      passes = !finished[i];
      for (int r = 0; r < nr && passes; r++) begin
        // A claim below the allocation gives a negative need, which always passes.
        need = int'(claim_mem[i*MAX_RES + r]) - int'(alloc_mem[i*MAX_RES + r]);
        if (need > int'(work[r])) begin
          passes = 1'b0;
        end
      end
      if (passes) begin
        for (int r = 0; r < nr; r++) begin
          sum     = int'(work[r]) + int'(alloc_mem[i*MAX_RES + r]);
          work[r] = (sum > WORK_MAX) ? WORK_BITS'(WORK_MAX) : WORK_BITS'(sum);
        end
        finished[i] = 1'b1;
        granted++;
        grants_due.push_back('{proc_id: PROC_BITS'(i), verdict: 1'b0, safe: 1'b0,
                               last: 1'b0});
        i = 0;
      end else begin
        i++;
      end
    end
    grants_due.push_back('{proc_id: '0, verdict: 1'b1, safe: (granted == np),
                           last: 1'b1});
  endtask

  always @(posedge clk) begin : monitor
    grant_t                want;
    logic [PROC_BITS-1:0]  pid;
    logic [RES_BITS-1:0]   rid;
    logic [COUNT_BITS-1:0] amt;
    if (!rst_n) begin
      procs_reg = CFG_BITS'(1);
      res_reg   = CFG_BITS'(1);
      grants_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == bsc_pkg::REG_PROCESS_COUNT) begin
          procs_reg = cfg_wdata;
        end else begin
          res_reg = cfg_wdata;
        end
      end
      if (in_tvalid && in_tready) begin
        pid = in_tdata[PROC_BITS-1:0];
        rid = in_tdata[PROC_BITS +: RES_BITS];
        amt = in_tdata[PROC_BITS+RES_BITS +: COUNT_BITS];
        case (in_tuser)
          bsc_pkg::CMD_LOAD_MAX:   claim_mem[pid*MAX_RES + rid] = amt;
          bsc_pkg::CMD_LOAD_ALLOC: alloc_mem[pid*MAX_RES + rid] = amt;
          bsc_pkg::CMD_LOAD_AVAIL: avail_mem[rid] = amt;
          bsc_pkg::CMD_RUN:        predict_safe_sequence();
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (grants_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: tdata %h tuser %b tlast %b",
                                    out_tdata, out_tuser, out_tlast));
        end else begin
          want = grants_due.pop_front();
          if (out_tdata[PROC_BITS-1:0] !== want.proc_id || out_tuser !== want.verdict ||
              out_tdata[PROC_BITS] !== want.safe || out_tlast !== want.last) begin
            report_mismatch($sformatf(
              "got proc %0d verdict %b safe %b last %b, expected %0d %b %b %b",
              out_tdata[PROC_BITS-1:0], out_tuser, out_tdata[PROC_BITS], out_tlast,
              want.proc_id, want.verdict, want.safe, want.last));
          end
        end
      end
    end
    outstanding <= grants_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety check unit testbench
// Drives load and run transactions into the safety check unit under a
// series of process and resource count settings, with random stalls on
// both streams, and lets the scoreboard compare every safe-sequence and
// verdict result against its own prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_PROCS  = bsc_pkg::MAX_PROCS;
  localparam int MAX_RES    = bsc_pkg::MAX_RES;
  localparam int COUNT_BITS = bsc_pkg::COUNT_BITS;
  localparam int PROC_BITS  = bsc_pkg::PROC_BITS;
  localparam int RES_BITS   = bsc_pkg::RES_BITS;
  localparam int TBL_DEPTH  = bsc_pkg::TBL_DEPTH;

  // Generous ceiling, far above the length of a correct test.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // This pause lets loads land before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int IDLE_PCT      = 21;
  localparam int PHASES        = 10;
  // During this phase neither side ever idles.
  localparam int CALM_PHASE    = 3;
  localparam int PHASE_ITEMS   = 35;
  localparam int PHASE_RUNS    = 1;

  // Flavors of one load-then-run sequence.
  typedef enum int {
    MIX_SMALL,     // small counts, so safe and unsafe verdicts both show up
    MIX_WIDE,      // zeros, all-ones and full-range counts
    MIX_SATURATE,  // every allocation at its maximum, so the work vector saturates
    MIX_NOISY      // small counts, then stray loads that may corrupt the set
  } mix_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [4:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int cycles    = 0;
  int sent      = 0;
  bit calm      = 1'b0;
  int eff_procs = 1;
  int eff_res   = 1;

  // Which table entries hold a value; a run must never read an unwritten one.
  bit claim_set [TBL_DEPTH];
  bit alloc_set [TBL_DEPTH];
  bit avail_set [MAX_RES];

  // Count settings, one pair per phase. Zero and values past the maximum are
  // included on purpose; the unit clamps them.
  logic [4:0] proc_plan [PHASES] = '{5'd1, 5'd0, 5'd3, 5'd4, 5'd16,
                                     5'd1, 5'd5, 5'd2, 5'd17, 5'd2};
  logic [4:0] res_plan  [PHASES] = '{5'd1, 5'd0, 5'd2, 5'd4, 5'd1,
                                     5'd16, 5'd3, 5'd7, 5'd2, 5'd31};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bankers_safety_check_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bsc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The receiver stalls on roughly one cycle in five, except in the calm phase.
  // Stalls land at random points of the scan, so any emit step may get held.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog. A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The unit reads a zero count as one and anything above the maximum as the
  // maximum; the stimulus needs the same view to know which entries a run reads.
  function automatic int usable_count(input logic [4:0] v, input int top);
    return (v == 0) ? 1 : ((v > top) ? top : int'(v));
  endfunction

  function automatic logic [COUNT_BITS-1:0] wide_amount();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return COUNT_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // Presents one transaction and returns at the edge where it is taken. The
  // sender may idle first; tvalid is only touched once per time step, so an
  // item that follows straight on keeps tvalid high without a glitch.
  task automatic send_item(input bsc_pkg::cmd_t kind, input logic [PROC_BITS-1:0] pid,
                           input logic [RES_BITS-1:0] rid,
                           input logic [COUNT_BITS-1:0] amount);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {amount, rid, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    case (kind)
      bsc_pkg::CMD_LOAD_MAX:   claim_set[pid*MAX_RES + rid] = 1'b1;
      bsc_pkg::CMD_LOAD_ALLOC: alloc_set[pid*MAX_RES + rid] = 1'b1;
      bsc_pkg::CMD_LOAD_AVAIL: avail_set[rid] = 1'b1;
      default: ;
    endcase
  endtask

  // Drops tvalid and waits until every predicted result has left the unit,
  // then gives any load still in flight time to land.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both count registers on back-to-back edges; cfg_we stays high
  // across the pair and drops afterwards.
  task automatic set_counts(input logic [4:0] procs, input logic [4:0] res);
    cfg_we    <= 1'b1;
    cfg_index <= bsc_pkg::REG_PROCESS_COUNT;
    cfg_wdata <= procs;
    @(posedge clk);
    cfg_index <= bsc_pkg::REG_RESOURCE_COUNT;
    cfg_wdata <= res;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eff_procs = usable_count(procs, MAX_PROCS);
    eff_res   = usable_count(res, MAX_RES);
  endtask

  // One well-formed sequence: loads for the entries in use, then a run. Small
  // sets and saturate-mix sets are rewritten in full; in large ones only a tenth
  // are refreshed, except entries never written, which a run must not read.
  task automatic run_scenario(input mix_t mix);
    int                    slot;
    int                    pct;
    logic [COUNT_BITS-1:0] held;
    logic [COUNT_BITS-1:0] claim;
    logic [COUNT_BITS-1:0] spare;
    pct = (eff_procs * eff_res <= 16) ? 100 : 10;
    for (int p = 0; p < eff_procs; p++) begin
      for (int r = 0; r < eff_res; r++) begin
        slot = p * MAX_RES + r;
        case (mix)
          MIX_WIDE: begin
            held  = wide_amount();
            claim = wide_amount();
          end
          MIX_SATURATE: begin
            held  = '1;
            claim = wide_amount();
          end
          default: begin
            held = COUNT_BITS'($urandom_range(0, 3));
            // Now and then the allocation exceeds the claim.
            if ($urandom_range(0, 11) == 0) begin
              claim = COUNT_BITS'($urandom_range(0, held));
            end else begin
              claim = held + COUNT_BITS'($urandom_range(0, 4));
            end
          end
        endcase
        if (mix == MIX_SATURATE || !claim_set[slot] || $urandom_range(0, 99) < pct) begin
          send_item(bsc_pkg::CMD_LOAD_MAX, PROC_BITS'(p), RES_BITS'(r), claim);
        end
        if (mix == MIX_SATURATE || !alloc_set[slot] || $urandom_range(0, 99) < pct) begin
          send_item(bsc_pkg::CMD_LOAD_ALLOC, PROC_BITS'(p), RES_BITS'(r), held);
        end
      end
    end
    for (int r = 0; r < eff_res; r++) begin
      case (mix)
        MIX_WIDE:     spare = wide_amount();
        MIX_SATURATE: spare = '1;
        default:      spare = COUNT_BITS'($urandom_range(0, 4));
      endcase
      if (mix == MIX_SATURATE || !avail_set[r] || $urandom_range(0, 99) < 60) begin
        // The process index is ignored on this load, so it is left random.
        send_item(bsc_pkg::CMD_LOAD_AVAIL, PROC_BITS'($urandom_range(0, MAX_PROCS - 1)),
                  RES_BITS'(r), spare);
      end
    end
    if (mix == MIX_NOISY) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(bsc_pkg::cmd_t'($urandom_range(0, 2)),
                  PROC_BITS'($urandom_range(0, MAX_PROCS - 1)),
                  RES_BITS'($urandom_range(0, MAX_RES - 1)), wide_amount());
      end
    end
    // The run ignores its data fields, so they carry random values.
    send_item(bsc_pkg::CMD_RUN, PROC_BITS'($urandom_range(0, MAX_PROCS - 1)),
              RES_BITS'($urandom_range(0, MAX_RES - 1)),
              COUNT_BITS'($urandom_range(0, 65535)));
  endtask

  initial begin : stimulus
    int   start;
    int   runs;
    mix_t mix;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on two processes and two resources. Process 0 claims
    // the full count of resource 0 and holds more of resource 1 than it
    // claims; process 1 fits the available counts exactly.
    set_counts(5'd2, 5'd2);
    send_item(bsc_pkg::CMD_LOAD_MAX,   4'd0, 4'd0, 16'hFFFF);
    send_item(bsc_pkg::CMD_LOAD_MAX,   4'd0, 4'd1, 16'h0000);
    send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd0, 4'd0, 16'h0000);
    send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd0, 4'd1, 16'hFFFF);
    send_item(bsc_pkg::CMD_LOAD_MAX,   4'd1, 4'd0, 16'd3);
    send_item(bsc_pkg::CMD_LOAD_MAX,   4'd1, 4'd1, 16'd5);
    send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd1, 4'd0, 16'd1);
    send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd1, 4'd1, 16'd2);
    send_item(bsc_pkg::CMD_LOAD_AVAIL, 4'd15, 4'd0, 16'd2);
    send_item(bsc_pkg::CMD_LOAD_AVAIL, 4'd9,  4'd1, 16'd3);
    // Process 1 is granted, process 0 never fits: unsafe.
    send_item(bsc_pkg::CMD_RUN, 4'd0, 4'd0, 16'h0000);
    // With the full count of resource 0 free both finish: safe.
    send_item(bsc_pkg::CMD_LOAD_AVAIL, 4'd0, 4'd0, 16'hFFFF);
    send_item(bsc_pkg::CMD_RUN, 4'd0, 4'd0, 16'h0000);
    // Highest indexes, alternating bit patterns, and a run with every data bit set.
    send_item(bsc_pkg::CMD_LOAD_MAX,   4'd15, 4'd15, 16'h5555);
    send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd15, 4'd15, 16'hAAAA);
    send_item(bsc_pkg::CMD_LOAD_AVAIL, 4'd15, 4'd15, 16'hFFFF);
    send_item(bsc_pkg::CMD_RUN, 4'd15, 4'd15, 16'hFFFF);

    // Random part, one count setting per phase. The registers only change
    // once the unit has drained.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      set_counts(proc_plan[ph], res_plan[ph]);
      calm  <= (ph == CALM_PHASE);
      start = sent;
      runs  = 0;
      while (sent - start < PHASE_ITEMS || runs < PHASE_RUNS) begin
        if (runs == 0 && eff_procs == MAX_PROCS) begin
          mix = MIX_SATURATE;
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    mix = MIX_WIDE;
            2, 3:    mix = MIX_NOISY;
            default: mix = MIX_SMALL;
          endcase
        end
        run_scenario(mix);
        runs++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
